@@ rtl/lmfb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the LED matrix frame buffer driver.
// No dependencies.
package lmfb_pkg;

  localparam int MOD_CNT_W   = 2;
  localparam int ROW_CNT_W   = 3;
  localparam int STEP_W      = 3;
  localparam int SETUP_STEPS = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [3:0] REG_DECODE    = 4'h9;
  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [3:0] REG_SCAN      = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
  localparam logic [3:0] REG_TEST      = 4'hF;
  localparam logic [7:0] SCAN_ALL      = 8'h07;
  localparam logic [7:0] NORMAL_OP     = 8'h01;
  localparam logic [7:0] MAX_LEVEL     = 8'd15;
  localparam logic [3:0] RESET_BRIGHT  = 4'd8;

  typedef enum logic [2:0] {
    CMD_DOT    = 3'd0,
    CMD_FILL   = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_BRIGHT = 3'd3,
    CMD_INIT   = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIRROR_X = 2'd0,
    CFG_MIRROR_Y = 2'd1,
    CFG_DEF_BRI  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SETUP,
    ST_ROWS,
    ST_BRIGHT
  } state_e;

  typedef enum logic [1:0] {
    SRC_SETUP,
    SRC_ROW,
    SRC_BRIGHT
  } src_e;

  typedef struct packed {
    logic                 load;
    logic                 dot_wr;
    logic                 fill_wr;
    logic                 clr_buf;
    logic                 emit;
    src_e                 src;
    logic [STEP_W-1:0]    step;
    logic [ROW_CNT_W-1:0] row;
    logic [MOD_CNT_W-1:0] mod;
    logic                 frame_end;
    logic                 last;
  } lmfb_ctrl_t;

  typedef struct packed {
    logic out_free;
    cmd_e cmd;
  } lmfb_status_t;

  function automatic logic [3:0] setup_addr(input logic [STEP_W-1:0] step);
    logic [3:0] a;
    case (step)
      3'd0:    a = REG_TEST;
      3'd1:    a = REG_DECODE;
      3'd2:    a = REG_SCAN;
      3'd3:    a = REG_INTENSITY;
      default: a = REG_SHUTDOWN;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] setup_data(input logic [STEP_W-1:0] step,
                                            input logic [3:0] bright);
    logic [7:0] d;
    case (step)
      3'd0:    d = 8'h00;
      3'd1:    d = 8'h00;
      3'd2:    d = SCAN_ALL;
      3'd3:    d = {4'h0, bright};
      default: d = NORMAL_OP;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/lmfb_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces: command items in, register pairs out, config writes.
// Depends on lmfb_pkg for the config port widths.
interface lmfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic       pixel_on;
  logic [7:0] level;
  modport source (output valid, cmd, x_pos, y_pos, pixel_on, level, input ready);
  modport sink   (input valid, cmd, x_pos, y_pos, pixel_on, level, output ready);
endinterface

interface lmfb_pair_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_addr;
  logic [7:0] reg_data;
  logic       frame_end;
  logic       last;
  modport source (output valid, reg_addr, reg_data, frame_end, last, input ready);
  modport sink   (input valid, reg_addr, reg_data, frame_end, last, output ready);
endinterface

interface lmfb_cfg_if import lmfb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/led_matrix_frame_buffer_driver.sv @@
`timescale 1ns / 1ps
// Top level of the LED matrix frame buffer driver: sequencer plus datapath.
// Depends on lmfb_pkg, lmfb_if, lmfb_ctrl and lmfb_dp.
// One command item is taken at a time. Dot and fill items are captured,
// then written into the buffer. Update emits MODULES*ROWS pairs,
// brightness MODULES, init 5*MODULES + MODULES*ROWS, each pair
// leaving the single output register one per cycle while the sink keeps
// ready high; a sink stall holds the next pair back. The next
// item is taken in the cycle after the last pair is loaded into the output
// register. Config writes are always ready.
module led_matrix_frame_buffer_driver import lmfb_pkg::*; #(
  parameter int MODULES = 2,
  parameter int ROWS    = 8
) (
  input logic         clk_i,
  input logic         rst_ni,
  lmfb_cmd_if.sink    cmd_in,
  lmfb_pair_if.source pair_out,
  lmfb_cfg_if.sink    cfg_wr
);

  lmfb_ctrl_t   ctrl;
  lmfb_status_t status;
  logic         in_ready;

  assign cmd_in.ready = in_ready;

  lmfb_ctrl #(
    .MODULES (MODULES),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_in.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  lmfb_dp #(
    .MODULES (MODULES),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_in.cmd),
    .x_pos_i     (cmd_in.x_pos),
    .y_pos_i     (cmd_in.y_pos),
    .pixel_on_i  (cmd_in.pixel_on),
    .level_i     (cmd_in.level),
    .cfg_valid_i (cfg_wr.valid),
    .cfg_index_i (cfg_wr.index),
    .cfg_data_i  (cfg_wr.data),
    .cfg_ready_o (cfg_wr.ready),
    .out_valid_o (pair_out.valid),
    .out_ready_i (pair_out.ready),
    .reg_addr_o  (pair_out.reg_addr),
    .reg_data_o  (pair_out.reg_data),
    .frame_end_o (pair_out.frame_end),
    .last_o      (pair_out.last),
    .ctrl_i      (ctrl),
    .status_o    (status)
  );

endmodule

@@ rtl/lmfb_ctrl.sv @@
`timescale 1ns / 1ps
// Command sequencer: dispatches items and walks the frame and module counters.
// Depends on lmfb_pkg.
module lmfb_ctrl import lmfb_pkg::*; #(
  parameter int MODULES = 2,
  parameter int ROWS    = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  lmfb_status_t status_i,
  output lmfb_ctrl_t   ctrl_o
);

  localparam logic [MOD_CNT_W-1:0] MOD_LAST  = MOD_CNT_W'(MODULES - 1);
  localparam logic [ROW_CNT_W-1:0] ROW_LAST  = ROW_CNT_W'(ROWS - 1);
  localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(SETUP_STEPS - 1);

  state_e               state_q, state_d;
  logic [MOD_CNT_W-1:0] mod_q, mod_d;
  logic [ROW_CNT_W-1:0] row_q, row_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic                 emit;
  logic                 mod_wrap;

  assign mod_wrap = (mod_q == MOD_LAST);
  assign emit = ((state_q == ST_SETUP) || (state_q == ST_ROWS) || (state_q == ST_BRIGHT))
                && status_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mod_q   <= '0;
      row_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      mod_q   <= mod_d;
      row_q   <= row_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (status_i.cmd)
          CMD_UPDATE: state_d = ST_ROWS;
          CMD_BRIGHT: state_d = ST_BRIGHT;
          CMD_INIT:   state_d = ST_SETUP;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_SETUP: begin
        if (emit && mod_wrap && (step_q == STEP_LAST)) state_d = ST_ROWS;
      end
      ST_ROWS: begin
        if (emit && mod_wrap && (row_q == ROW_LAST)) state_d = ST_IDLE;
      end
      ST_BRIGHT: begin
        if (emit && mod_wrap) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mod_d  = mod_q;
    row_d  = row_q;
    step_d = step_q;
    if (state_q == ST_IDLE) begin
      mod_d  = '0;
      row_d  = '0;
      step_d = '0;
    end else if (emit) begin
      if (mod_wrap) begin
        mod_d = '0;
        if (state_q == ST_SETUP) begin
          step_d = (step_q == STEP_LAST) ? '0 : step_q + 1'b1;
        end
        if (state_q == ST_ROWS) begin
          row_d = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
        end
      end else begin
        mod_d = mod_q + 1'b1;
      end
    end
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    ctrl_o.load      = in_valid_i && (state_q == ST_IDLE);
    ctrl_o.dot_wr    = (state_q == ST_EXEC) && (status_i.cmd == CMD_DOT);
    ctrl_o.fill_wr   = (state_q == ST_EXEC) && (status_i.cmd == CMD_FILL);
    ctrl_o.clr_buf   = (state_q == ST_SETUP);
    ctrl_o.emit      = emit;
    ctrl_o.step      = step_q;
    ctrl_o.row       = row_q;
    ctrl_o.mod       = mod_q;
    ctrl_o.frame_end = mod_wrap;
    ctrl_o.last      = mod_wrap && ((state_q == ST_BRIGHT)
                       || ((state_q == ST_ROWS) && (row_q == ROW_LAST)));
    case (state_q)
      ST_SETUP:  ctrl_o.src = SRC_SETUP;
      ST_BRIGHT: ctrl_o.src = SRC_BRIGHT;
      default:   ctrl_o.src = SRC_ROW;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> status_i.out_free)
    else $error("pair emitted into a full output register");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && ctrl_o.last) |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after the last pair");
  a_last_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && ctrl_o.last) |-> (mod_q == MOD_LAST))
    else $error("last pair not at the end of a frame");
  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_q <= MOD_LAST) && (row_q <= ROW_LAST))
    else $error("module or row counter out of range");
`endif

endmodule

@@ rtl/lmfb_dp.sv @@
`timescale 1ns / 1ps
// Datapath: item and config registers, frame buffer, dot address logic, pair output register.
// Depends on lmfb_pkg.
module lmfb_dp import lmfb_pkg::*; #(
  parameter int MODULES = 2,
  parameter int ROWS    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [2:0]            cmd_i,
  input  logic [7:0]            x_pos_i,
  input  logic [7:0]            y_pos_i,
  input  logic                  pixel_on_i,
  input  logic [7:0]            level_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            reg_addr_o,
  output logic [7:0]            reg_data_o,
  output logic                  frame_end_o,
  output logic                  last_o,
  input  lmfb_ctrl_t            ctrl_i,
  output lmfb_status_t          status_o
);

  localparam int BUF_LEN = MODULES * ROWS;
  localparam int DISP_W  = MODULES * 8;
  localparam int IDX_W   = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
  localparam logic signed [9:0] X_MAX = 10'(DISP_W - 1);
  localparam logic signed [9:0] X_LIM = 10'(DISP_W);
  localparam logic signed [9:0] Y_MAX = 10'(ROWS - 1);
  localparam logic signed [9:0] Y_LIM = 10'(ROWS);

  cmd_e       cmd_q;
  logic [7:0] x_q, y_q, level_q;
  logic       pixel_q;
  logic       mirror_x_q, mirror_y_q;
  logic [3:0] bright_q;

  logic [7:0] frame_q [BUF_LEN];

  logic       out_valid_q;
  logic [3:0] addr_q;
  logic [7:0] data_q;
  logic       fend_q, last_q;

  logic signed [9:0] xs, ys, xm, ym;
  logic              dot_ok;
  logic [IDX_W-1:0]  dot_idx, row_idx;
  logic [3:0]        bright_clamp;
  logic [3:0]        pair_addr;
  logic [7:0]        pair_data;

  assign cfg_ready_o       = 1'b1;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.cmd      = cmd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_e'(cmd_i);
      x_q     <= x_pos_i;
      y_q     <= y_pos_i;
      pixel_q <= pixel_on_i;
      level_q <= level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_x_q <= 1'b0;
      mirror_y_q <= 1'b0;
      bright_q   <= RESET_BRIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIRROR_X: mirror_x_q <= cfg_data_i[0];
        CFG_MIRROR_Y: mirror_y_q <= cfg_data_i[0];
        CFG_DEF_BRI:  bright_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    xs      = signed'({{2{x_q[7]}}, x_q});
    ys      = signed'({{2{y_q[7]}}, y_q});
    xm      = mirror_x_q ? (X_MAX - xs) : xs;
    ym      = mirror_y_q ? (Y_MAX - ys) : ys;
    dot_ok  = !xm[9] && (xm < X_LIM) && !ym[9] && (ym < Y_LIM);
    dot_idx = IDX_W'(int'(MODULES - 1) - int'(xm[4:3]) + int'(ym[2:0]) * MODULES);
    row_idx = IDX_W'(int'(ctrl_i.row) * MODULES + int'(ctrl_i.mod));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUF_LEN; i++) frame_q[i] <= '0;
    end else begin
      for (int i = 0; i < BUF_LEN; i++) begin
        if (ctrl_i.clr_buf) begin
          frame_q[i] <= '0;
        end else if (ctrl_i.fill_wr) begin
          frame_q[i] <= {8{pixel_q}};
        end else if (ctrl_i.dot_wr && dot_ok && (dot_idx == IDX_W'(i))) begin
          frame_q[i][xm[2:0]] <= pixel_q;
        end
      end
    end
  end

  assign bright_clamp = (level_q > MAX_LEVEL) ? MAX_LEVEL[3:0] : level_q[3:0];

  always_comb begin
    case (ctrl_i.src)
      SRC_SETUP: begin
        pair_addr = setup_addr(ctrl_i.step);
        pair_data = setup_data(ctrl_i.step, bright_q);
      end
      SRC_BRIGHT: begin
        pair_addr = REG_INTENSITY;
        pair_data = {4'h0, bright_clamp};
      end
      default: begin
        pair_addr = 4'(ROWS - int'(ctrl_i.row));
        pair_data = frame_q[row_idx];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      addr_q <= pair_addr;
      data_q <= pair_data;
      fend_q <= ctrl_i.frame_end;
      last_q <= ctrl_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reg_addr_o  = addr_q;
  assign reg_data_o  = data_q;
  assign frame_end_o = fend_q;
  assign last_o      = last_q;

endmodule
